@@ design/hilbert_envelope_inst_freq_top_assert.svh @@
// Assertion macros used by the top-level design file.
`ifndef HILBERT_ENVELOPE_INST_FREQ_TOP_ASSERT_SVH
`define HILBERT_ENVELOPE_INST_FREQ_TOP_ASSERT_SVH

// Same-cycle implication.
`define HEI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HEI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/hilenv_pkg.sv @@
package hilenv_pkg;

   // Filter geometry
   localparam int TAPS        = 32;
   localparam int HALF        = TAPS / 2;
   localparam int WIN         = TAPS + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int TIME_W      = 32;
   localparam int AMP_W       = 18;
   localparam int PH_W        = 16;

   // Window memory and sequence counter
   localparam int WADDR_W = $clog2(WIN);
   localparam int FILL_W  = $clog2(WIN + 1);
   localparam int CNT_W   = WADDR_W;
   localparam int MEM_W   = TIME_W + SAMPLE_BITS;

   // Shared multiplier and accumulator
   localparam int COEF_W = 16;
   localparam int XH_W   = 20;
   localparam int OP_W   = XH_W;
   localparam int PROD_W = 2 * OP_W;
   localparam int ACC_W  = PROD_W;
   localparam int RND_SH = 16;

   // Square root and CORDIC
   localparam int ROOT_W       = 2 * AMP_W;
   localparam int SQRT_STEPS   = AMP_W;
   localparam int CORDIC_STEPS = 15;
   localparam int SHIFT_W      = 4;
   localparam int CORDIC_FRAC  = 16;
   localparam int CW           = XH_W + CORDIC_FRAC + 2;
   localparam int ITER_STEPS   = SQRT_STEPS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_SQX,
      ST_SQH,
      ST_SQSUM,
      ST_SETUP,
      ST_ITER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             accept;
      logic             start_clr;
      logic             acc_clr;
      logic             rd_en;
      logic [CNT_W-1:0] idx;
      logic             sq_x;
      logic             sq_xh;
      logic             round;
      logic             setup;
      logic             iter;
      logic             load;
   } ctrl_type;

   // Combined weight of window position m: sum of the two adjacent Hilbert taps
   // that act on it in the two half-shifted filter passes (Q1.15).
   function automatic logic signed [COEF_W-1:0] coef(input logic [CNT_W-1:0] m);
      logic signed [COEF_W-1:0] c;
      begin
         unique case (m)
            6'd0:  c = 16'sd673;
            6'd1:  c = 16'sd1392;
            6'd2:  c = 16'sd1492;
            6'd3:  c = 16'sd1607;
            6'd4:  c = 16'sd1741;
            6'd5:  c = 16'sd1900;
            6'd6:  c = 16'sd2091;
            6'd7:  c = 16'sd2325;
            6'd8:  c = 16'sd2618;
            6'd9:  c = 16'sd2996;
            6'd10: c = 16'sd3501;
            6'd11: c = 16'sd4214;
            6'd12: c = 16'sd5298;
            6'd13: c = 16'sd7152;
            6'd14: c = 16'sd11126;
            6'd15: c = 16'sd27815;
            6'd17: c = -16'sd27815;
            6'd18: c = -16'sd11126;
            6'd19: c = -16'sd7152;
            6'd20: c = -16'sd5298;
            6'd21: c = -16'sd4214;
            6'd22: c = -16'sd3501;
            6'd23: c = -16'sd2996;
            6'd24: c = -16'sd2618;
            6'd25: c = -16'sd2325;
            6'd26: c = -16'sd2091;
            6'd27: c = -16'sd1900;
            6'd28: c = -16'sd1741;
            6'd29: c = -16'sd1607;
            6'd30: c = -16'sd1492;
            6'd31: c = -16'sd1392;
            6'd32: c = -16'sd673;
            default: c = '0;
         endcase
         return c;
      end
   endfunction

   // Arctangent of 2^-i in 1/65536 turn
   function automatic logic [PH_W-1:0] atan_step(input logic [SHIFT_W-1:0] i);
      logic [PH_W-1:0] a;
      begin
         unique case (i)
            4'd0:  a = 16'd8192;
            4'd1:  a = 16'd4836;
            4'd2:  a = 16'd2555;
            4'd3:  a = 16'd1297;
            4'd4:  a = 16'd651;
            4'd5:  a = 16'd326;
            4'd6:  a = 16'd163;
            4'd7:  a = 16'd81;
            4'd8:  a = 16'd41;
            4'd9:  a = 16'd20;
            4'd10: a = 16'd10;
            4'd11: a = 16'd5;
            4'd12: a = 16'd3;
            4'd13: a = 16'd1;
            4'd14: a = 16'd1;
            default: a = '0;
         endcase
         return a;
      end
   endfunction

endpackage

@@ design/hilenv_window.sv @@
module hilenv_window (
   input  logic                                     clock,
   input  logic                                     reset,
   input  hilenv_pkg::ctrl_type                     ctl,
   input  logic signed [hilenv_pkg::SAMPLE_BITS-1:0] wr_sample,
   input  logic [hilenv_pkg::TIME_W-1:0]            wr_time,
   input  logic                                     wr_start,
   output logic signed [hilenv_pkg::SAMPLE_BITS-1:0] rd_sample,
   output logic [hilenv_pkg::TIME_W-1:0]            rd_time,
   output logic                                     full_next
);
   import hilenv_pkg::*;

   logic [MEM_W-1:0]   mem [WIN];
   logic [MEM_W-1:0]   rd_data_ff;
   logic [WADDR_W-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in, fill_step;
   logic [WADDR_W:0]   addr_sum;
   logic [WADDR_W:0]   addr_wrap;
   logic [WADDR_W-1:0] rd_addr;

   // Count stored samples, restart on a new record, hold at a full window
   always_comb begin
      if (wr_start) begin
         fill_step = FILL_W'(1);
      end else if (fill_ff == FILL_W'(WIN)) begin
         fill_step = fill_ff;
      end else begin
         fill_step = fill_ff + FILL_W'(1);
      end
      full_next = (fill_step == FILL_W'(WIN));
      fill_in   = ctl.accept ? fill_step : fill_ff;
   end

   // Advance the circular write pointer; the slot after the newest is the oldest
   always_comb begin
      if (!ctl.accept) begin
         wp_in = wp_ff;
      end else if (wp_ff == WADDR_W'(WIN - 1)) begin
         wp_in = '0;
      end else begin
         wp_in = wp_ff + WADDR_W'(1);
      end
   end

   // Map window position to memory address
   always_comb begin
      addr_sum  = {1'b0, wp_ff} + {1'b0, ctl.idx};
      addr_wrap = addr_sum - (WADDR_W + 1)'(WIN);
      rd_addr   = (addr_sum >= (WADDR_W + 1)'(WIN)) ? addr_wrap[WADDR_W-1:0]
                                                   : addr_sum[WADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   // Store the transfer
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         mem[wp_ff] <= {wr_time, wr_sample};
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_sample = rd_data_ff[SAMPLE_BITS-1:0];
   assign rd_time   = rd_data_ff[MEM_W-1:SAMPLE_BITS];

endmodule

@@ design/hilenv_ctrl.sv @@
module hilenv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_start_req,
   input  logic                 full_next,
   input  logic                 out_free,
   output logic                 req_stall,
   output hilenv_pkg::ctrl_type ctl
);
   import hilenv_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && full_next) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (cnt_ff == CNT_W'(WIN - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = '0;
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_ROUND: state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQH;
         ST_SQH:   state_in = ST_SQSUM;
         ST_SQSUM: state_in = ST_SETUP;
         ST_SETUP: begin
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (cnt_ff == CNT_W'(ITER_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      ctl           = '0;
      ctl.idx       = cnt_ff;
      req_stall     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            ctl.acc_clr   = 1'b1;
            ctl.accept    = req_valid;
            ctl.start_clr = req_valid && req_start_req;
         end
         ST_MAC:   ctl.rd_en = 1'b1;
         ST_DRAIN: ctl.rd_en = 1'b0;
         ST_ROUND: begin
            ctl.round   = 1'b1;
            ctl.acc_clr = 1'b1;
         end
         ST_SQX:   ctl.sq_x  = 1'b1;
         ST_SQH:   ctl.sq_xh = 1'b1;
         ST_SQSUM: ctl.sq_xh = 1'b0;
         ST_SETUP: ctl.setup = 1'b1;
         ST_ITER:  ctl.iter  = 1'b1;
         ST_DONE:  ctl.load  = out_free;
         default:  ctl.load  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ design/hilenv_arith.sv @@
module hilenv_arith (
   input  logic                                      clock,
   input  logic                                      reset,
   input  hilenv_pkg::ctrl_type                      ctl,
   input  logic signed [hilenv_pkg::SAMPLE_BITS-1:0] rd_sample,
   input  logic [hilenv_pkg::TIME_W-1:0]             rd_time,
   input  logic                                      rsp_stall,
   output logic                                      out_free,
   output logic                                      rsp_valid,
   output logic [hilenv_pkg::TIME_W-1:0]             rsp_centre_time,
   output logic [hilenv_pkg::AMP_W-1:0]              rsp_amplitude,
   output logic [hilenv_pkg::PH_W-1:0]               rsp_phase_step
);
   import hilenv_pkg::*;

   // Read tag pipeline
   logic                        rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;

   // Shared multiplier and accumulator
   logic signed [OP_W-1:0]      op_a, op_b;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic                        prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     rnd_sum;

   // Centre sample and quadrature value
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [TIME_W-1:0]           time_ff, time_in;
   logic signed [XH_W-1:0]      xh_ff, xh_in;

   // Square root
   logic [ROOT_W-1:0]           rem_ff, rem_in;
   logic [ROOT_W-1:0]           root_ff, root_in;
   logic [ROOT_W-1:0]           bit_ff, bit_in;
   logic [ROOT_W-1:0]           trial;
   logic                        sat_ff, sat_in;

   // CORDIC
   logic signed [CW-1:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0]        xs, ys, sx, sy;
   logic [PH_W-1:0]             ang_ff, ang_in;
   logic                        zero_ff, zero_in;
   logic                        cordic_on;
   logic [SHIFT_W-1:0]          sh;

   // Output and phase history
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]           ctime_ff, ctime_in;
   logic [AMP_W-1:0]            amp_ff, amp_in;
   logic [PH_W-1:0]             step_ff, step_in;
   logic [PH_W-1:0]             prev_ff, prev_in;
   logic [PH_W-1:0]             ph_fin;

   // Tag the window read so its data meets the right weight
   always_comb begin
      rd_vld_in = ctl.rd_en;
      rd_idx_in = ctl.idx;
   end

   // Select multiplier operands: filter product or one of the squares
   always_comb begin
      priority if (ctl.sq_x) begin
         op_a = OP_W'(x_ff);
         op_b = OP_W'(x_ff);
      end else if (ctl.sq_xh) begin
         op_a = xh_ff;
         op_b = xh_ff;
      end else begin
         op_a = OP_W'(rd_sample);
         op_b = OP_W'(coef(rd_idx_ff));
      end
      prod_in     = op_a * op_b;
      prod_vld_in = rd_vld_ff || ctl.sq_x || ctl.sq_xh;
   end

   // Accumulate products; clear while idle and between the filter sum and the sum of squares
   always_comb begin
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   // Capture the centre sample and its time tag as it streams by
   always_comb begin
      if (rd_vld_ff && (rd_idx_ff == CNT_W'(HALF))) begin
         x_in    = rd_sample;
         time_in = rd_time;
      end else begin
         x_in    = x_ff;
         time_in = time_ff;
      end
   end

   // Round the sum of both half-shifted filter outputs into the quadrature value
   always_comb begin
      rnd_sum = acc_ff + (ACC_W'(1) <<< (RND_SH - 1));
      xh_in   = ctl.round ? rnd_sum[RND_SH +: XH_W] : xh_ff;
   end

   // Restoring square root, one result bit per step
   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      sat_in  = sat_ff;
      if (ctl.setup) begin
         sat_in  = |acc_ff[ACC_W-1:ROOT_W];
         rem_in  = acc_ff[ROOT_W-1:0];
         root_in = '0;
         bit_in  = ROOT_W'(1) << (ROOT_W - 2);
      end else if (ctl.iter) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   // CORDIC vectoring: fold the left half plane, then drive y toward zero
   always_comb begin
      xs        = {{(CW - SAMPLE_BITS - CORDIC_FRAC){x_ff[SAMPLE_BITS-1]}}, x_ff,
                   {CORDIC_FRAC{1'b0}}};
      ys        = {{(CW - XH_W - CORDIC_FRAC){xh_ff[XH_W-1]}}, xh_ff,
                   {CORDIC_FRAC{1'b0}}};
      sh        = ctl.idx[SHIFT_W-1:0];
      sx        = cx_ff >>> sh;
      sy        = cy_ff >>> sh;
      cordic_on = ctl.iter && (ctl.idx < CNT_W'(CORDIC_STEPS));
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      ang_in    = ang_ff;
      zero_in   = zero_ff;
      if (ctl.setup) begin
         zero_in = (x_ff == '0) && (xh_ff == '0);
         if (x_ff[SAMPLE_BITS-1]) begin
            cx_in  = -xs;
            cy_in  = -ys;
            ang_in = PH_W'(1) << (PH_W - 1);
         end else begin
            cx_in  = xs;
            cy_in  = ys;
            ang_in = '0;
         end
      end else if (cordic_on) begin
         if (!cy_ff[CW-1]) begin
            cx_in  = cx_ff + sy;
            cy_in  = cy_ff - sx;
            ang_in = ang_ff + atan_step(sh);
         end else begin
            cx_in  = cx_ff - sy;
            cy_in  = cy_ff + sx;
            ang_in = ang_ff - atan_step(sh);
         end
      end
   end

   // Load the result register and update the phase history
   always_comb begin
      ph_fin       = zero_ff ? '0 : ang_ff;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = ctl.load || (rsp_valid_ff && rsp_stall);
      ctime_in     = ctime_ff;
      amp_in       = amp_ff;
      step_in      = step_ff;
      prev_in      = prev_ff;
      if (ctl.start_clr) begin
         prev_in = '0;
      end else if (ctl.load) begin
         ctime_in = time_ff;
         amp_in   = sat_ff ? '1 : root_ff[AMP_W-1:0];
         step_in  = ph_fin - prev_ff;
         prev_in  = ph_fin;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      time_ff   <= time_in;
      xh_ff     <= xh_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      sat_ff    <= sat_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      ang_ff    <= ang_in;
      zero_ff   <= zero_in;
      ctime_ff  <= ctime_in;
      amp_ff    <= amp_in;
      step_ff   <= step_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centre_time = ctime_ff;
   assign rsp_amplitude   = amp_ff;
   assign rsp_phase_step  = step_ff;

endmodule

@@ design/hilbert_envelope_inst_freq_top.sv @@
// Hilbert envelope and instantaneous frequency. Each transfer on req_ carries a
// signed Q2.14 sample and its time tag into a 33-entry circular window. Once the
// window holds 33 samples of the current record (req_start_req begins a record
// and clears the phase history), the block produces one rsp_ transfer: the time
// tag of the centre sample, the envelope sqrt(x^2 + xh^2) as unsigned Q4.14
// (saturating), and the phase step against the previous result in 1/65536 turn.
// A transfer that does not complete the window is taken without a stall. One
// that does keeps req_stall high while the block streams the window through the
// single multiplier and memory read port, drains, rounds and forms the squares
// on that same multiplier, seeds the square root and the CORDIC, runs the
// bit-serial square root with the 15 CORDIC steps alongside, and loads the
// output register. The load waits while a stalled earlier result still
// occupies the register. A finished result sits in an output register, so
// the next sample is taken while it waits.
module hilbert_envelope_inst_freq_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [hilenv_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic [hilenv_pkg::TIME_W-1:0]             req_sample_time,
   input  logic                                      req_start_req,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [hilenv_pkg::TIME_W-1:0]             rsp_centre_time,
   output logic [hilenv_pkg::AMP_W-1:0]              rsp_amplitude,
   output logic [hilenv_pkg::PH_W-1:0]               rsp_phase_step
);
   import hilenv_pkg::*;

`include "hilbert_envelope_inst_freq_top_assert.svh"

   ctrl_type                      ctl;
   logic signed [SAMPLE_BITS-1:0] rd_sample;
   logic [TIME_W-1:0]             rd_time;
   logic                          full_next;
   logic                          out_free;

   hilenv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .full_next     (full_next),
      .out_free      (out_free),
      .req_stall     (req_stall),
      .ctl           (ctl)
   );

   hilenv_window u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_sample (req_sample),
      .wr_time   (req_sample_time),
      .wr_start  (req_start_req),
      .rd_sample (rd_sample),
      .rd_time   (rd_time),
      .full_next (full_next)
   );

   hilenv_arith u_arith (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .rd_sample       (rd_sample),
      .rd_time         (rd_time),
      .rsp_stall       (rsp_stall),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_centre_time (rsp_centre_time),
      .rsp_amplitude   (rsp_amplitude),
      .rsp_phase_step  (rsp_phase_step)
   );

   // Check sequencing between the window, the shared unit and the output register
   `HEI_ASSERT_NOW(a_no_read_while_open, clock, reset, !req_stall, !ctl.rd_en, "window read while input open")
   `HEI_ASSERT_NOW(a_load_only_when_free, clock, reset, ctl.load, (!rsp_valid || !rsp_stall), "result loaded over a stalled one")
   `HEI_ASSERT_NEXT(a_load_shows_result, clock, reset, ctl.load, rsp_valid, "loaded result not presented")
   `HEI_ASSERT_NOW(a_result_from_load, clock, reset, $rose(rsp_valid), $past(ctl.load), "result appeared without a load")

endmodule

@@ tb/tb_hilbert_envelope_inst_freq_top.sv @@
`timescale 1ns / 1ps

localparam longint unsigned PI_Q30      = 64'd3373259426;
localparam int              TAG_DEPTH   = hilenv_pkg::HALF + 1;
localparam int              AMP_CEILING = (1 << hilenv_pkg::AMP_W) - 1;

typedef struct packed {
   logic [hilenv_pkg::TIME_W-1:0] centre_time;
   logic [hilenv_pkg::AMP_W-1:0]  amplitude;
   logic [hilenv_pkg::PH_W-1:0]   phase_step;
} envelope_result_type;

// Track sample and tag windows, predict envelope and phase step, check results
class envelope_phase_board;
   longint                        sample_win[hilenv_pkg::WIN];
   logic [hilenv_pkg::TIME_W-1:0] tag_win[TAG_DEPTH];
   longint                        hilbert_tap[hilenv_pkg::TAPS + 1];
   logic [hilenv_pkg::PH_W-1:0]   arctan_turn[hilenv_pkg::CORDIC_STEPS];
   int                            fill;
   logic [hilenv_pkg::PH_W-1:0]   last_angle;
   envelope_result_type           awaited[$];
   int                            failures;

   function new();
      int                k;
      int                d;
      longint unsigned   den;
      longint unsigned   q;
      fill       = 0;
      last_angle = '0;
      failures   = 0;
      arctan_turn = '{16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163,
                      16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1};
      foreach (sample_win[i]) sample_win[i] = 0;
      foreach (tag_win[i]) tag_win[i] = '0;
      // Q1.15 taps 1/(pi*(k - TAPS/2 - 0.5)), rounded half away from zero
      hilbert_tap[0] = 0;
      for (k = 1; k <= hilenv_pkg::TAPS; k++) begin
         d   = 2 * k - hilenv_pkg::TAPS - 1;
         den = PI_Q30 * longint'(d < 0 ? -d : d);
         q   = ((64'd1 << 47) + den) / (2 * den);
         hilbert_tap[k] = (d < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned one;
      r   = 0;
      one = 64'd1 << 62;
      while (one > n) one = one >> 2;
      while (one != 0) begin
         if (n >= r + one) begin
            n = n - (r + one);
            r = (r >> 1) + one;
         end else begin
            r = r >> 1;
         end
         one = one >> 2;
      end
      return r;
   endfunction

   // CORDIC vectoring angle in 1/65536 turn
   function logic [hilenv_pkg::PH_W-1:0] vector_angle(longint x, longint y);
      logic [hilenv_pkg::PH_W-1:0] ang;
      longint                      nx;
      longint                      ny;
      int                          i;
      ang = '0;
      if (x == 0 && y == 0) return '0;
      x = x * 65536;
      y = y * 65536;
      if (x < 0) begin
         x   = -x;
         y   = -y;
         ang = 16'd32768;
      end
      for (i = 0; i < hilenv_pkg::CORDIC_STEPS; i++) begin
         if (y >= 0) begin
            nx  = x + (y >>> i);
            ny  = y - (x >>> i);
            ang = ang + arctan_turn[i];
         end else begin
            nx  = x - (y >>> i);
            ny  = y + (x >>> i);
            ang = ang - arctan_turn[i];
         end
         x = nx;
         y = ny;
      end
      return ang;
   endfunction

   function void note_sample(logic signed [hilenv_pkg::SAMPLE_BITS-1:0] s,
                             logic [hilenv_pkg::TIME_W-1:0] tag, logic start);
      longint                      acc_a;
      longint                      acc_b;
      longint                      xh;
      longint                      x;
      longint unsigned             root;
      logic [hilenv_pkg::PH_W-1:0] ang;
      envelope_result_type         r;
      int                          j;
      if (start) begin
         fill       = 0;
         last_angle = '0;
      end
      // Shift both windows, newest last
      for (j = 0; j < hilenv_pkg::WIN - 1; j++) sample_win[j] = sample_win[j + 1];
      sample_win[hilenv_pkg::WIN - 1] = longint'(s);
      for (j = 0; j < TAG_DEPTH - 1; j++) tag_win[j] = tag_win[j + 1];
      tag_win[TAG_DEPTH - 1] = tag;
      if (fill < hilenv_pkg::WIN) fill++;
      if (fill < hilenv_pkg::WIN) return;

      // Two half-shifted filter passes, averaged
      acc_a = 0;
      acc_b = 0;
      for (j = 0; j < hilenv_pkg::TAPS; j++) begin
         acc_a += sample_win[j] * hilbert_tap[hilenv_pkg::TAPS - j];
         acc_b += sample_win[j + 1] * hilbert_tap[hilenv_pkg::TAPS - j];
      end
      xh = (acc_a + acc_b + 32768) >>> 16;
      x  = sample_win[hilenv_pkg::HALF];

      root = root_floor(longint'(x * x) + longint'(xh * xh));
      if (root > AMP_CEILING) root = AMP_CEILING;
      ang = vector_angle(x, xh);

      r.centre_time = tag_win[0];
      r.amplitude   = root[hilenv_pkg::AMP_W-1:0];
      r.phase_step  = ang - last_angle;
      last_angle    = ang;
      awaited.push_back(r);
   endfunction

   function void check_result(envelope_result_type got);
      envelope_result_type want;
      if (awaited.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result: time=%h amp=%0d step=%0d",
                     got.centre_time, got.amplitude, got.phase_step);
         return;
      end
      want = awaited.pop_front();
      if (got.centre_time !== want.centre_time || got.amplitude !== want.amplitude ||
          got.phase_step !== want.phase_step) begin
         failures++;
         if (failures <= 10)
            $display("mismatch: expected time=%h amp=%0d step=%0d, got time=%h amp=%0d step=%0d",
                     want.centre_time, want.amplitude, want.phase_step,
                     got.centre_time, got.amplitude, got.phase_step);
      end
   endfunction

   function int pending_count();
      return awaited.size();
   endfunction
endclass

module tb_hilbert_envelope_inst_freq_top;
   import hilenv_pkg::*;

   localparam int ITEMS       = 950;
   localparam int QUIET_TAIL  = 120;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum int {FILL_RANDOM, FILL_SMALL, FILL_EXTREME, FILL_ZERO, FILL_TONE} fill_kind_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic [TIME_W-1:0]             req_sample_time = '0;
   logic                          req_start_req = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [TIME_W-1:0]             rsp_centre_time;
   logic [AMP_W-1:0]              rsp_amplitude;
   logic [PH_W-1:0]               rsp_phase_step;

   envelope_phase_board board;
   int                  sent = 0;
   int                  cycle_count = 0;
   logic                quiet = 1'b0;

   logic signed [SAMPLE_BITS-1:0] extreme_vals[7] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                                      16'sh0001, 16'shFFFF, 16'sh5555,
                                                      16'shAAAA};
   logic [TIME_W-1:0]             tag_vals[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h5555_5555, 32'hAAAA_AAAA};

   hilbert_envelope_inst_freq_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_sample_time (req_sample_time),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_centre_time (rsp_centre_time),
      .rsp_amplitude   (rsp_amplitude),
      .rsp_phase_step  (rsp_phase_step)
   );

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Check results before noting inputs taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result(envelope_result_type'{rsp_centre_time, rsp_amplitude,
                                                     rsp_phase_step});
         if (req_valid && !req_stall)
            board.note_sample(req_sample, req_sample_time, req_start_req);
      end
   end

   // Stall the result channel in random bursts, none in the quiet tail
   initial begin
      logic stall_on;
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            stall_on = ($urandom_range(0, 2) == 0);
            rsp_stall <= stall_on;
            repeat (stall_on ? $urandom_range(1, 19) : $urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] sample_for(fill_kind_type kind, int idx,
                                                                real rate, int amp);
      logic [31:0] raw;
      int          v;
      raw = $urandom();
      case (kind)
         FILL_RANDOM:  v = int'(raw[15:0]);
         FILL_SMALL:   v = int'($urandom_range(0, 128)) - 64;
         FILL_EXTREME: v = raw[0] ? 32767 : -32768;
         FILL_ZERO:    v = 0;
         default:      v = $rtoi(amp * $sin(rate * idx));
      endcase
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Offer one sample, optionally after a gap, and hold it until taken
   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic [TIME_W-1:0] tag,
                              logic start);
      quiet = (sent >= ITEMS - QUIET_TAIL);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_sample_time <= tag;
      req_start_req   <= start;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Idle the sender until every awaited result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_count() != 0);
   endtask

   initial begin
      int            k;
      int            pick;
      int            len;
      int            amp;
      real           rate;
      logic [31:0]   base;
      logic          drained;
      fill_kind_type kind;
      drained = 1'b0;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, a restart inside a partial window
      for (k = 0; k < 20; k++)
         send_sample(extreme_vals[k % 7], tag_vals[k % 4], (k == 0 || k == 12));

      // Records: mostly complete windows, some short ones and stray samples
      while (sent < ITEMS) begin
         if (!drained && sent >= 400) begin
            drain_results();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 9);
         base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 60) : $urandom();
         if (pick == 0)
            len = 1;
         else if (pick == 1)
            len = $urandom_range(1, WIN - 1);
         else
            len = $urandom_range(WIN + 1, 90);
         kind = fill_kind_type'($urandom_range(0, 4));
         amp  = $urandom_range(1, 32767);
         rate = $urandom_range(1, 600) / 1000.0;
         for (k = 0; k < len && sent < ITEMS; k++)
            send_sample(sample_for(kind, k, rate, amp), base + k,
                        (pick == 0) ? 1'($urandom_range(0, 1)) : (k == 0));
      end

      drain_results();
      repeat (80) @(posedge clock);
      if (board.failures == 0 && board.pending_count() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
